// ===== rtl/vsid_pkg.sv =====
// ----------------------------------------------------------------------------
// vsid_pkg
// Shared types and constants of the spot inactivity detector.
// ----------------------------------------------------------------------------
package vsid_pkg;

    localparam int PIXEL_BITS = 8;
    localparam int POS_BITS   = 11;
    localparam int SUM_BITS   = 12;
    localparam int TOL_BITS   = 4;
    localparam int TUNIT_BITS = 4;
    localparam int RATE_BITS  = 6;
    localparam int LIMIT_BITS = TUNIT_BITS + RATE_BITS;
    localparam int STILL_BITS = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = POS_BITS;

    localparam logic [STILL_BITS-1:0] STILL_MAX = STILL_BITS'(60000);
    localparam logic [PIXEL_BITS-1:0] PIX_MAX   = {PIXEL_BITS{1'b1}};

    // sum / 9 == (sum * DIV9_MUL) >> DIV9_SHIFT, exact for any 12-bit sum
    localparam int DIV9_SHIFT = 15;
    localparam logic [SUM_BITS-1:0] DIV9_MUL = SUM_BITS'(3641);
    localparam int PROD_BITS  = 2 * SUM_BITS;
    localparam int QUOT_BITS  = PROD_BITS - DIV9_SHIFT;

    // queue between classifier and executor
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_ROWS    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_COLS    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPOT_ROW      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPOT_COL      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT_UNITS = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_RATE    = 3'd6;

    typedef struct packed {
        logic [POS_BITS-1:0] frame_rows;
        logic [POS_BITS-1:0] frame_cols;
        logic [POS_BITS-1:0] spot_row;
        logic [POS_BITS-1:0] spot_col;
    } t_geom_cfg;

    typedef struct packed {
        logic [TOL_BITS-1:0]   tolerance;
        logic [TUNIT_BITS-1:0] timeout_units;
        logic [RATE_BITS-1:0]  frame_rate;
    } t_judge_cfg;

    // one classified pixel as it travels through the queue
    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic                  user;
        logic                  last;
        logic                  eof;
        logic [SUM_BITS-1:0]   sum;
    } t_item;

endpackage

// ===== rtl/video_spot_inactivity_detector_top.sv =====
// ----------------------------------------------------------------------------
// video_spot_inactivity_detector_top
// Pass-through grey video stream with a 3x3 spot inactivity LED.
// ----------------------------------------------------------------------------
// Takes one pixel per clock, sustained while the sink keeps accepting. Each
// pixel appears unchanged on the master side, with its led flag, after the
// queue, the divide stage and the output register, and later while the sink
// stalls. Under back-pressure up to six pixels are held (four in the queue,
// one in the divide stage, one in the output register) before tready drops.
// Pixel throughput is bounded only by the single output register, which takes
// a new pixel in every cycle the sink accepts one.
// Raster position follows the configured frame size only; tuser and tlast
// are copied but never move the position. Register writes go through
// i_cfg_we/i_cfg_idx/i_cfg_data and must be done while no pixel is in flight.
module video_spot_inactivity_detector_top import vsid_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,  // [7:0] pixel_in
    input  logic                     s_axis_tuser,  // user_in
    input  logic                     s_axis_tlast,  // last_in
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [15:0]              m_axis_tdata,  // [7:0] pixel_out, [8] led, rest 0
    output logic                     m_axis_tuser,  // user_out
    output logic                     m_axis_tlast   // last_out
);

    t_geom_cfg  r_geom;
    t_judge_cfg r_judge;

    logic                  q_full;
    logic                  accept;
    t_item                 fr_item;
    logic                  q_valid;
    t_item                 q_item;
    logic                  q_pop;
    logic [PIXEL_BITS-1:0] out_pixel;
    logic                  out_led;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.frame_rows     <= POS_BITS'(1080);
            r_geom.frame_cols     <= POS_BITS'(1920);
            r_geom.spot_row       <= POS_BITS'(540);
            r_geom.spot_col       <= POS_BITS'(960);
            r_judge.tolerance     <= TOL_BITS'(4);
            r_judge.timeout_units <= TUNIT_BITS'(1);
            r_judge.frame_rate    <= RATE_BITS'(30);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_ROWS:    r_geom.frame_rows     <= i_cfg_data[POS_BITS-1:0];
                REG_FRAME_COLS:    r_geom.frame_cols     <= i_cfg_data[POS_BITS-1:0];
                REG_SPOT_ROW:      r_geom.spot_row       <= i_cfg_data[POS_BITS-1:0];
                REG_SPOT_COL:      r_geom.spot_col       <= i_cfg_data[POS_BITS-1:0];
                REG_TOLERANCE:     r_judge.tolerance     <= i_cfg_data[TOL_BITS-1:0];
                REG_TIMEOUT_UNITS: r_judge.timeout_units <= i_cfg_data[TUNIT_BITS-1:0];
                REG_FRAME_RATE:    r_judge.frame_rate    <= i_cfg_data[RATE_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;

    vsid_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_geom   (r_geom),
        .i_accept (accept),
        .i_pixel  (s_axis_tdata[PIXEL_BITS-1:0]),
        .i_user   (s_axis_tuser),
        .i_last   (s_axis_tlast),
        .o_item   (fr_item)
    );

    vsid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (fr_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    vsid_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_judge   (r_judge),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_pixel   (out_pixel),
        .o_user    (m_axis_tuser),
        .o_last    (m_axis_tlast),
        .o_led     (out_led)
    );

    assign m_axis_tdata = {7'b0, out_led, out_pixel};

endmodule

// ===== rtl/vsid_front.sv =====
// ----------------------------------------------------------------------------
// vsid_front
// Raster position tracking, window accumulation and end-of-frame marking.
// ----------------------------------------------------------------------------
module vsid_front import vsid_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_geom_cfg             i_geom,
    input  logic                  i_accept,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    input  logic                  i_user,
    input  logic                  i_last,
    output t_item                 o_item
);

    logic [POS_BITS-1:0] r_row, n_row;
    logic [POS_BITS-1:0] r_col, n_col;
    logic [SUM_BITS-1:0] r_sum, n_sum;

    logic                in_win;
    logic                line_end;
    logic                frame_end;
    logic [SUM_BITS-1:0] sum_acc;

    // centre-1 <= pos <= centre+1, done without negatives
    function automatic logic near_centre(input logic [POS_BITS-1:0] pos,
                                         input logic [POS_BITS-1:0] ctr);
        logic [POS_BITS:0] p;
        logic [POS_BITS:0] c;
        p = {1'b0, pos};
        c = {1'b0, ctr};
        return ((p + (POS_BITS+1)'(2)) > c) && (p < (c + (POS_BITS+1)'(2)));
    endfunction

    always_comb begin
        in_win    = near_centre(r_row, i_geom.spot_row) && near_centre(r_col, i_geom.spot_col);
        sum_acc   = in_win ? (r_sum + SUM_BITS'(i_pixel)) : r_sum;
        line_end  = ({1'b0, r_col} + (POS_BITS+1)'(1)) >= {1'b0, i_geom.frame_cols};
        frame_end = line_end
                 && (({1'b0, r_row} + (POS_BITS+1)'(1)) >= {1'b0, i_geom.frame_rows});

        n_row = r_row;
        n_col = r_col;
        n_sum = r_sum;
        if (i_accept) begin
            n_sum = frame_end ? '0 : sum_acc;
            if (line_end) begin
                n_col = '0;
                n_row = frame_end ? '0 : (r_row + POS_BITS'(1));
            end else begin
                n_col = r_col + POS_BITS'(1);
            end
        end

        o_item.pixel = i_pixel;
        o_item.user  = i_user;
        o_item.last  = i_last;
        o_item.eof   = frame_end;
        o_item.sum   = sum_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_sum <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            r_sum <= n_sum;
        end
    end

endmodule

// ===== rtl/vsid_queue.sv =====
// ----------------------------------------------------------------------------
// vsid_queue
// Short register FIFO between classifier and executor.
// ----------------------------------------------------------------------------
module vsid_queue import vsid_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item                r_mem [QDEPTH];
    logic [QPTR_BITS-1:0] r_wr, n_wr;
    logic [QPTR_BITS-1:0] r_rd, n_rd;
    logic [QCNT_BITS-1:0] r_cnt, n_cnt;

    logic do_push;
    logic do_pop;

    always_comb begin
        o_full  = (r_cnt == QCNT_BITS'(QDEPTH));
        o_valid = (r_cnt != '0);
        o_item  = r_mem[r_rd];
        do_push = i_push && !o_full;
        do_pop  = i_pop && o_valid;
        n_wr    = do_push ? r_wr + QPTR_BITS'(1) : r_wr;
        n_rd    = do_pop ? r_rd + QPTR_BITS'(1) : r_rd;
        n_cnt   = r_cnt + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_BITS'(QDEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !o_full && !(i_pop && o_valid)) |=> r_cnt == $past(r_cnt) + QCNT_BITS'(1))
        else $error("queue count did not follow push");

endmodule

// ===== rtl/vsid_back.sv =====
// ----------------------------------------------------------------------------
// vsid_back
// Divide-by-9 stage, still-frame judgment and output register.
// ----------------------------------------------------------------------------
module vsid_back import vsid_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_judge_cfg            i_judge,
    input  logic                  i_q_valid,
    input  t_item                 i_q_item,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PIXEL_BITS-1:0] o_pixel,
    output logic                  o_user,
    output logic                  o_last,
    output logic                  o_led
);

    // stage 1: quotient
    logic                  r_s1_valid;
    logic [PIXEL_BITS-1:0] r_s1_pixel;
    logic                  r_s1_user;
    logic                  r_s1_last;
    logic                  r_s1_eof;
    logic [QUOT_BITS-1:0]  r_s1_quot;

    // stage 2: output
    logic                  r_out_valid;
    logic [PIXEL_BITS-1:0] r_out_pixel;
    logic                  r_out_user;
    logic                  r_out_last;
    logic                  r_out_led;

    logic [STILL_BITS-1:0] r_still, n_still;
    logic [PIXEL_BITS-1:0] r_prev, n_prev;
    logic                  r_led, n_led;

    logic                  adv;
    logic                  s1_load;
    logic [PROD_BITS-1:0]  prod;
    logic [PIXEL_BITS-1:0] avg;
    logic [PIXEL_BITS-1:0] tol8;
    logic [PIXEL_BITS-1:0] prev_c;
    logic [PIXEL_BITS:0]   lo_b;
    logic [PIXEL_BITS:0]   hi_b;
    logic                  close;
    logic [LIMIT_BITS-1:0] limit;

    always_comb begin
        adv     = !r_out_valid || i_ready;
        s1_load = adv || !r_s1_valid;
        o_q_pop = i_q_valid && s1_load;
        prod    = PROD_BITS'(i_q_item.sum) * PROD_BITS'(DIV9_MUL);

        avg    = (r_s1_quot > QUOT_BITS'(PIX_MAX)) ? PIX_MAX : r_s1_quot[PIXEL_BITS-1:0];
        tol8   = PIXEL_BITS'(i_judge.tolerance);
        // clamp previous average into [tol, 255-tol]
        if (r_prev < tol8) begin
            prev_c = tol8;
        end else if (r_prev > (PIX_MAX - tol8)) begin
            prev_c = PIX_MAX - tol8;
        end else begin
            prev_c = r_prev;
        end
        lo_b  = {1'b0, prev_c} - {1'b0, tol8};
        hi_b  = {1'b0, prev_c} + {1'b0, tol8};
        close = (lo_b < {1'b0, avg}) && ({1'b0, avg} < hi_b);
        limit = LIMIT_BITS'(i_judge.timeout_units) * LIMIT_BITS'(i_judge.frame_rate);

        n_still = r_still;
        n_prev  = r_prev;
        n_led   = r_led;
        if (adv && r_s1_valid && r_s1_eof) begin
            if (close) begin
                n_still = (r_still < STILL_MAX) ? r_still + STILL_BITS'(1) : r_still;
            end else begin
                n_still = '0;
            end
            n_prev = avg;
            n_led  = !(n_still > STILL_BITS'(limit));
        end

        o_valid = r_out_valid;
        o_pixel = r_out_pixel;
        o_user  = r_out_user;
        o_last  = r_out_last;
        o_led   = r_out_led;
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_pixel <= i_q_item.pixel;
            r_s1_user  <= i_q_item.user;
            r_s1_last  <= i_q_item.last;
            r_s1_eof   <= i_q_item.eof;
            r_s1_quot  <= prod[PROD_BITS-1:DIV9_SHIFT];
        end
        if (adv) begin
            r_out_pixel <= r_s1_pixel;
            r_out_user  <= r_s1_user;
            r_out_last  <= r_s1_last;
            r_out_led   <= n_led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_still     <= '0;
            r_prev      <= '0;
            r_led       <= 1'b1;
        end else begin
            if (s1_load) begin
                r_s1_valid <= i_q_valid;
            end
            if (adv) begin
                r_out_valid <= r_s1_valid;
            end
            r_still <= n_still;
            r_prev  <= n_prev;
            r_led   <= n_led;
        end
    end

    a_still_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_still <= STILL_MAX)
        else $error("still count beyond saturation");

    a_clear_led_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_still == '0) |-> r_led)
        else $error("led off with zero still count");

    a_judge_only_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(adv && r_s1_valid && r_s1_eof) |=> $stable(r_still) && $stable(r_prev))
        else $error("judgment state moved without end of frame");

endmodule

// ===== bench/video_spot_inactivity_detector_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_spot_inactivity_detector_top_tb
// Self-checking bench for the spot inactivity detector.
// ----------------------------------------------------------------------------
// Pixels are queued per phase. A clocked driver sends them with random gaps,
// and a predictor follows the raster position, the 3x3 spot sum, the
// still-frame count and the led. A clocked monitor stalls at random and
// checks every result against the oldest prediction. Phases change the
// frame geometry, the spot, the tolerance and the timeout, and only do so
// while nothing is in flight. Most frames repeat a scene with small jitter,
// so that the still counter climbs and the led drops.
// ----------------------------------------------------------------------------
module video_spot_inactivity_detector_top_tb import vsid_pkg::*; ();

    localparam int STALL_LIMIT      = 1000;
    localparam int NUM_SCENE_PHASES = 14;
    localparam int PIX_PER_PHASE    = 52;

    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} t_idle;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic                  user;
        logic                  last;
    } t_pix_req;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic                  user;
        logic                  last;
        logic                  led;
    } t_pix_resp;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [7:0]               s_axis_tdata = '0;   // [7:0] pixel_in
    logic                     s_axis_tuser = 1'b0; // user_in
    logic                     s_axis_tlast = 1'b0; // last_in
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [15:0]              m_axis_tdata;        // [7:0] pixel_out, [8] led
    logic                     m_axis_tuser;        // user_out
    logic                     m_axis_tlast;        // last_out

    video_spot_inactivity_detector_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // register copies
    logic [POS_BITS-1:0]   cfg_rows, cfg_cols, cfg_spot_row, cfg_spot_col;
    logic [TOL_BITS-1:0]   cfg_tol;
    logic [TUNIT_BITS-1:0] cfg_tunits;
    logic [RATE_BITS-1:0]  cfg_rate;

    // predicted block state
    logic [POS_BITS-1:0]   pos_row, pos_col;
    logic [SUM_BITS-1:0]   win_sum;
    int                    prev_avg;
    int                    still_frames;
    logic                  led_now;

    t_pix_req  pending_pixels[$];
    t_pix_resp expected_pixels[$];

    t_idle src_idle_mode = IDLE_NONE;
    t_idle snk_idle_mode = IDLE_NONE;
    int    src_wait, snk_wait;
    int    stall_cycles = 0;
    int    err_cnt = 0;
    int    pixels_sent = 0;
    int    results_seen = 0;
    int    frames_closed = 0;
    int    led_low_seen = 0;
    int    settings_used = 0;

    logic [PIXEL_BITS-1:0] scene [8][8];

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int draw_idle(input t_idle mode);
        case (mode)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 4)) : 0;
            default:    return $urandom_range(0, 16);
        endcase
    endfunction

    function automatic bit near_spot(input int p, input int centre);
        return (centre - 2 < p) && (p < centre + 2);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    // advance the spot tracker by one accepted pixel and queue its result
    task automatic track_spot_pixel(input t_pix_req req);
        t_pix_resp resp;
        int        quot, prev, tol;
        if (near_spot(int'(pos_row), int'(cfg_spot_row)) &&
            near_spot(int'(pos_col), int'(cfg_spot_col)))
            win_sum = win_sum + req.pixel;
        if (int'(pos_col) + 1 >= int'(cfg_cols)) begin
            pos_col = '0;
            if (int'(pos_row) + 1 >= int'(cfg_rows)) begin
                pos_row = '0;
                quot = int'(win_sum) / 9;
                if (quot > 255) quot = 255;
                tol = int'(cfg_tol);
                prev = prev_avg;
                // previous average clamped with the tolerance now in force
                if (prev < tol) prev = tol;
                else if (prev > 255 - tol) prev = 255 - tol;
                if ((prev - tol < quot) && (quot < prev + tol)) begin
                    if (still_frames < 60000) still_frames++;
                end else begin
                    still_frames = 0;
                end
                prev_avg = quot;
                win_sum = '0;
                led_now = (still_frames > int'(cfg_tunits) * int'(cfg_rate)) ? 1'b0 : 1'b1;
                frames_closed++;
            end else begin
                pos_row = pos_row + 1'b1;
            end
        end else begin
            pos_col = pos_col + 1'b1;
        end
        resp.pixel = req.pixel;
        resp.user  = req.user;
        resp.last  = req.last;
        resp.led   = led_now;
        expected_pixels.push_back(resp);
    endtask

    // source side
    always @(posedge i_clk) begin
        t_pix_req req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_wait = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                req.pixel = s_axis_tdata;
                req.user  = s_axis_tuser;
                req.last  = s_axis_tlast;
                track_spot_pixel(req);
                pixels_sent++;
                src_wait = draw_idle(src_idle_mode);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    req = pending_pixels.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= req.pixel;
                    s_axis_tuser  <= req.user;
                    s_axis_tlast  <= req.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side
    always @(posedge i_clk) begin
        t_pix_resp want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            snk_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (m_axis_tdata[8] === 1'b0) led_low_seen++;
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("result pixel %0d with no request pending",
                                              m_axis_tdata[7:0]));
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_axis_tdata[7:0] !== want.pixel)
                        report_mismatch($sformatf("result %0d pixel: got %0d want %0d",
                                                  results_seen, m_axis_tdata[7:0], want.pixel));
                    if (m_axis_tuser !== want.user)
                        report_mismatch($sformatf("result %0d user: got %b want %b",
                                                  results_seen, m_axis_tuser, want.user));
                    if (m_axis_tlast !== want.last)
                        report_mismatch($sformatf("result %0d last: got %b want %b",
                                                  results_seen, m_axis_tlast, want.last));
                    if (m_axis_tdata[8] !== want.led)
                        report_mismatch($sformatf("result %0d led: got %b want %b",
                                                  results_seen, m_axis_tdata[8], want.led));
                end
                snk_wait = draw_idle(snk_idle_mode);
            end
            if (snk_wait > 0) begin
                snk_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog: cycles in which neither side moves a request
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     stall_cycles, expected_pixels.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_BITS'(value);
    endtask

    task automatic apply_settings(input int rows, input int cols, input int srow,
                                  input int scol, input int tol, input int tunits,
                                  input int rate);
        write_reg(REG_FRAME_ROWS, rows);
        write_reg(REG_FRAME_COLS, cols);
        write_reg(REG_SPOT_ROW, srow);
        write_reg(REG_SPOT_COL, scol);
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_TIMEOUT_UNITS, tunits);
        write_reg(REG_FRAME_RATE, rate);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_rows     = POS_BITS'(rows);
        cfg_cols     = POS_BITS'(cols);
        cfg_spot_row = POS_BITS'(srow);
        cfg_spot_col = POS_BITS'(scol);
        cfg_tol      = TOL_BITS'(tol);
        cfg_tunits   = TUNIT_BITS'(tunits);
        cfg_rate     = RATE_BITS'(rate);
        settings_used++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_pixels.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0);
        // pipeline holds up to six pixels
        repeat (10) @(negedge i_clk);
    endtask

    task automatic push_pixel(input int pixel, input bit user, input bit last);
        t_pix_req req;
        req.pixel = PIXEL_BITS'(pixel);
        req.user  = user;
        req.last  = last;
        pending_pixels.push_back(req);
    endtask

    task automatic paint_scene();
        int r, c, pick;
        for (r = 0; r < 8; r++) begin
            for (c = 0; c < 8; c++) begin
                pick = $urandom_range(0, 9);
                scene[r][c] = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
            end
        end
    endtask

    // frames that mostly repeat one scene with a little jitter, flags mostly
    // consistent with the raster and now and then flipped
    task automatic queue_scene_frames(input int n_pix);
        int r, c, n, v, jit;
        t_pix_req req;
        r = int'(pos_row);
        c = int'(pos_col);
        paint_scene();
        jit = $urandom_range(0, 1);
        for (n = 0; n < n_pix; n++) begin
            v = int'(scene[r & 7][c & 7]) + int'($urandom_range(0, 2 * jit)) - jit;
            if (v < 0) v = 0;
            else if (v > 255) v = 255;
            req.pixel = v[7:0];
            req.user  = (r == 0 && c == 0);
            req.last  = (c + 1 >= int'(cfg_cols));
            if ($urandom_range(0, 11) == 0) req.user = ~req.user;
            if ($urandom_range(0, 11) == 0) req.last = ~req.last;
            pending_pixels.push_back(req);
            if (c + 1 >= int'(cfg_cols)) begin
                c = 0;
                if (r + 1 >= int'(cfg_rows)) begin
                    r = 0;
                    if ($urandom_range(0, 9) < 3) begin
                        paint_scene();
                        jit = $urandom_range(0, 1);
                    end
                end else begin
                    r++;
                end
            end else begin
                c++;
            end
        end
    endtask

    initial begin
        int ph, rows, cols, srow, scol, tol, tunits, rate;
        cfg_rows     = 11'd1080;
        cfg_cols     = 11'd1920;
        cfg_spot_row = 11'd540;
        cfg_spot_col = 11'd960;
        cfg_tol      = 4'd4;
        cfg_tunits   = 4'd1;
        cfg_rate     = 6'd30;
        pos_row      = '0;
        pos_col      = '0;
        win_sum      = '0;
        prev_avg     = 0;
        still_frames = 0;
        led_now      = 1'b1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset geometry: no frame can end, led stays high
        push_pixel(0, 1'b1, 1'b0);
        push_pixel(255, 1'b0, 1'b1);
        push_pixel(8'hAA, 1'b1, 1'b1);
        push_pixel(8'h55, 1'b0, 1'b0);
        wait_idle();

        // one-pixel frames: still count climbs past a threshold of one, then clears
        src_idle_mode = IDLE_HEAVY;
        snk_idle_mode = IDLE_HEAVY;
        apply_settings(1, 1, 0, 0, 4, 1, 1);
        push_pixel(200, 1'b1, 1'b1);
        push_pixel(200, 1'b1, 1'b1);
        push_pixel(200, 1'b1, 1'b1);
        push_pixel(200, 1'b1, 1'b1);
        push_pixel(0, 1'b1, 1'b1);
        push_pixel(255, 1'b1, 1'b1);
        wait_idle();

        // zero frame size, spot far off the frame, zero tolerance, largest timeout
        apply_settings(0, 0, 2047, 2047, 0, 15, 63);
        push_pixel(17, 1'b0, 1'b1);
        push_pixel(17, 1'b1, 1'b0);
        push_pixel(255, 1'b0, 1'b0);
        push_pixel(0, 1'b1, 1'b1);
        wait_idle();

        // largest frame, spot on the border, widest tolerance, zero timeout
        apply_settings(2047, 2047, 0, 2046, 15, 0, 0);
        push_pixel(255, 1'b1, 1'b0);
        push_pixel(255, 1'b0, 1'b0);
        push_pixel(0, 1'b0, 1'b0);
        push_pixel(128, 1'b0, 1'b1);
        push_pixel(1, 1'b1, 1'b1);
        push_pixel(254, 1'b0, 1'b0);
        wait_idle();

        for (ph = 0; ph < NUM_SCENE_PHASES; ph++) begin
            src_idle_mode = t_idle'(ph % 3);
            snk_idle_mode = t_idle'((ph / 3) % 3);
            rows = $urandom_range(0, 4);
            cols = $urandom_range(0, 6);
            srow = ($urandom_range(0, 9) < 7) ? $urandom_range(0, rows) : $urandom_range(0, 2047);
            scol = ($urandom_range(0, 9) < 7) ? $urandom_range(0, cols) : $urandom_range(0, 2047);
            tol = ($urandom_range(0, 9) < 6) ? $urandom_range(2, 6) : $urandom_range(0, 15);
            tunits = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(0, 15);
            rate = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(0, 63);
            apply_settings(rows, cols, srow, scol, tol, tunits, rate);
            queue_scene_frames(PIX_PER_PHASE);
            wait_idle();
        end

        $display("Checked %0d of %0d pixels over %0d register settings, %0d frame ends.",
                 results_seen, pixels_sent, settings_used, frames_closed);
        $display("Led was low on %0d results; geometry and threshold extremes included.",
                 led_low_seen);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
